[rtl/mrbt_pkg.sv]
package mrbt_pkg;

  // Field widths of the channel words
  localparam int unsigned FIELD_W   = 64;
  localparam int unsigned VERDICT_W = 2;

  // Verdict codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_SKIPPED = 2'd0,
    VERDICT_PRIME   = 2'd1,
    VERDICT_WITNESS = 2'd2,
    VERDICT_INVALID = 2'd3
  } verdict_t;

endpackage

[rtl/mrbt_in_if.sv]
interface mrbt_in_if;
  logic                             valid;
  logic                             ready;
  logic [mrbt_pkg::FIELD_W-1:0]     modulus;
  logic [mrbt_pkg::FIELD_W-1:0]     base;

  modport source (output valid, output modulus, output base, input ready);
  modport sink   (input valid, input modulus, input base, output ready);
endinterface

[rtl/mrbt_out_if.sv]
interface mrbt_out_if;
  logic                             valid;
  logic                             ready;
  logic [mrbt_pkg::VERDICT_W-1:0]   verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

[rtl/mrbt_modmul.sv]
// Bit-serial modular multiply: one bit of y per cycle, MSB first.
// acc = (2*acc + y_bit*x) mod m, operands below m, m >= 2.
module mrbt_modmul #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, x_r, ysh_r, m_r;
  logic [W:0]    m2_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  logic [W+1:0]  v;
  logic [W+2:0]  d1, d2;
  logic [W-1:0]  acc_nxt;

  // double-and-add, then drop by m or 2m
  always_comb begin
    v  = {1'b0, acc_r, 1'b0} + (ysh_r[W-1] ? {2'b00, x_r} : '0);
    d1 = {1'b0, v} - {3'b000, m_r};
    d2 = {1'b0, v} - {2'b00, m2_r};
    if (!d2[W+2]) begin
      acc_nxt = d2[W-1:0];
    end else if (!d1[W+2]) begin
      acc_nxt = d1[W-1:0];
    end else begin
      acc_nxt = v[W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      ysh_r <= y;
      m_r   <= m;
      m2_r  <= {m, 1'b0};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      ysh_r <= {ysh_r[W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

[rtl/mrbt_gcd.sv]
// Binary gcd, one shift or subtract per cycle; reports only gcd == 1.
module mrbt_gcd #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] u,
  input  logic [W-1:0] v,
  output logic         done,
  output logic         coprime
);

  logic [W-1:0] u_r, v_r;
  logic         busy_r, done_r, cop_r;
  logic [W:0]   diff;

  assign diff = {1'b0, u_r} - {1'b0, v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (u_r == '0 || v_r == '0 || (!u_r[0] && !v_r[0])) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u_r <= u;
      v_r <= v;
    end else if (busy_r) begin
      // terminal cases: one side zero, or a common factor of two
      if (u_r == '0) begin
        cop_r <= (v_r == W'(1));
      end else if (v_r == '0) begin
        cop_r <= (u_r == W'(1));
      end else if (!u_r[0] && !v_r[0]) begin
        cop_r <= 1'b0;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (!diff[W]) begin
        u_r <= diff[W-1:0];
      end else begin
        v_r <= v_r - u_r;
      end
    end
  end

  assign done    = done_r;
  assign coprime = cop_r;

endmodule

[rtl/miller_rabin_base_test_unit.sv]
// Strong probable prime test of one modulus n against one base a.
// in_if (sink): a word carries modulus and base; only the low NUM_BITS bits
//   of each are used. Accepted when valid and ready are high at a clock edge.
// out_if (source): one word per input word carrying the verdict:
//   skipped (gcd not 1), probable prime, witness, or invalid (n below 2).
// An invalid modulus goes straight to the done state and from there into
// the output register. Otherwise the work runs through one bit-serial
// modular multiplier: one reduction of a mod n, a binary gcd of up to
// about 2*NUM_BITS steps, up to NUM_BITS shifts to split n-1, then up to
// 2*NUM_BITS - 1 products for the power and the s-1 squarings after it
// together, fewer for short or sparse exponents. A word is taken only when
// the previous one is finished, so the engine holds one word at a time.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver stalls, a second finished verdict holds in the
// engine until the output register frees.
// Reset (rst_n, synchronous, active low) empties the engine and the output.
module miller_rabin_base_test_unit #(
  parameter int unsigned NUM_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  mrbt_in_if.sink    in_if,
  mrbt_out_if.source out_if
);

  localparam int unsigned W  = NUM_BITS;
  localparam int unsigned SW = $clog2(W + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED, ST_GCD, ST_SPLIT, ST_POW, ST_PMUL, ST_PSQ,
    ST_CHECK, ST_SQ_GO, ST_SQ, ST_DONE
  } state_t;

  state_t                 state_r;
  logic [W-1:0]           n_r, nm1_r, x_r, acc_r, e_r;
  logic [SW-1:0]          s_r;
  mrbt_pkg::verdict_t     verdict_r, out_verdict_r;
  logic                   out_valid_r;

  logic                   mul_start, mul_done, gcd_start, gcd_done, coprime;
  logic [W-1:0]           mul_x, mul_y, mul_res;
  logic                   in_acc, out_free;
  logic [W-1:0]           in_n;

  assign in_acc   = in_if.valid && (state_r == ST_IDLE);
  assign in_n     = in_if.modulus[W-1:0];
  assign out_free = !out_valid_r || out_if.ready;

  // multiplier / gcd launches
  always_comb begin
    mul_start = 1'b0;
    mul_x     = x_r;
    mul_y     = x_r;
    gcd_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        mul_start = in_acc && (in_n[W-1:1] != '0);
        mul_x     = W'(1);
        mul_y     = in_if.base[W-1:0];
      end
      ST_RED: gcd_start = mul_done;
      ST_POW: begin
        mul_start = e_r[0] || (e_r[W-1:1] != '0);
        mul_x     = e_r[0] ? acc_r : x_r;
        mul_y     = x_r;
      end
      ST_SQ_GO: begin
        mul_start = (s_r != '0);
        mul_x     = acc_r;
        mul_y     = acc_r;
      end
      default: ;
    endcase
  end

  mrbt_modmul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .x(mul_x), .y(mul_y), .m(state_r == ST_IDLE ? in_n : n_r),
    .done(mul_done), .res(mul_res)
  );

  mrbt_gcd #(.W(W)) u_gcd (
    .clk(clk), .rst_n(rst_n), .start(gcd_start),
    .u(n_r), .v(mul_res), .done(gcd_done), .coprime(coprime)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // ST_DONE reloads the output register itself
      if (out_valid_r && out_if.ready && (state_r != ST_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_acc) begin
          n_r <= in_n;
          if (in_n[W-1:1] == '0) begin
            verdict_r <= mrbt_pkg::VERDICT_INVALID;
            state_r   <= ST_DONE;
          end else begin
            state_r <= ST_RED;
          end
        end
        ST_RED: if (mul_done) begin
          x_r     <= mul_res;
          state_r <= ST_GCD;
        end
        ST_GCD: if (gcd_done) begin
          if (!coprime) begin
            verdict_r <= mrbt_pkg::VERDICT_SKIPPED;
            state_r   <= ST_DONE;
          end else begin
            nm1_r   <= n_r - W'(1);
            e_r     <= n_r - W'(1);
            s_r     <= '0;
            state_r <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (!e_r[0]) begin
            e_r <= e_r >> 1;
            s_r <= s_r + SW'(1);
          end else begin
            acc_r   <= W'(1);
            state_r <= ST_POW;
          end
        end
        ST_POW: begin
          if (e_r[0]) begin
            state_r <= ST_PMUL;
          end else if (e_r[W-1:1] != '0) begin
            state_r <= ST_PSQ;
          end else begin
            state_r <= ST_CHECK;
          end
        end
        ST_PMUL: if (mul_done) begin
          acc_r   <= mul_res;
          e_r[0]  <= 1'b0;
          state_r <= ST_POW;
        end
        ST_PSQ: if (mul_done) begin
          x_r     <= mul_res;
          e_r     <= e_r >> 1;
          state_r <= ST_POW;
        end
        ST_CHECK: begin
          if (acc_r == W'(1) || acc_r == nm1_r) begin
            verdict_r <= mrbt_pkg::VERDICT_PRIME;
            state_r   <= ST_DONE;
          end else begin
            verdict_r <= mrbt_pkg::VERDICT_WITNESS;
            if (s_r <= SW'(1)) begin
              state_r <= ST_DONE;
            end else begin
              s_r     <= s_r - SW'(1);
              state_r <= ST_SQ_GO;
            end
          end
        end
        ST_SQ_GO: state_r <= (s_r == '0) ? ST_DONE : ST_SQ;
        ST_SQ: if (mul_done) begin
          acc_r <= mul_res;
          if (mul_res == nm1_r) begin
            verdict_r <= mrbt_pkg::VERDICT_PRIME;
            state_r   <= ST_DONE;
          end else if (mul_res == W'(1)) begin
            state_r <= ST_DONE;
          end else begin
            s_r     <= s_r - SW'(1);
            state_r <= ST_SQ_GO;
          end
        end
        ST_DONE: if (out_free) begin
          out_valid_r   <= 1'b1;
          out_verdict_r <= verdict_r;
          state_r       <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_if.ready    = (state_r == ST_IDLE);
  assign out_if.valid   = out_valid_r;
  assign out_if.verdict = out_verdict_r;

endmodule

[rtl/mrbt_checker.sv]
module mrbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] verdict
);

  logic [1:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // stalled verdict holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("verdict changed while stalled");

  // no verdict without a word behind it
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("verdict without input word");

  // at most one word in the engine plus one in the output register
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r < 2'd2)
    else $error("too many words outstanding");

  // after reset nothing is offered
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict offered after reset");

endmodule

bind miller_rabin_base_test_unit mrbt_checker u_mrbt_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .verdict(out_if.verdict)
);
